FILE: hw/rtl/rcfe_pkg.sv
`timescale 1ns / 1ps

package rcfe_pkg;

   localparam int MAX_DIM    = 4096;
   localparam int MAX_STRIDE = 8192;

   localparam int POS_W    = $clog2(MAX_DIM);
   localparam int DIM_W    = $clog2(MAX_DIM + 1);
   localparam int STRIDE_W = $clog2(MAX_STRIDE + 1);
   localparam int ADDR_W   = 25;
   localparam int PIX_W    = 32;
   localparam int SHIFT_W  = 5;
   localparam int FIELD_W  = 16;
   localparam int COLOR_W  = 8;
   localparam int CLIP_W   = FIELD_W + 2;
   localparam int PROD_W   = POS_W + STRIDE_W;

   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 16;
   localparam int CSR_DIM_BITS  = 13;
   localparam int CSR_STR_BITS  = 14;

   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 64;

   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLE        = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCREEN_WIDTH  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCREEN_HEIGHT = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_STRIDE    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_RED_POS       = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_GREEN_POS     = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLUE_POS      = 3'd6;

   localparam logic REQ_DRAW    = 1'b0;
   localparam logic REQ_ADVANCE = 1'b1;

   localparam logic [1:0] OP_PIXEL = 2'd0;
   localparam logic [1:0] OP_HSPAN = 2'd1;
   localparam logic [1:0] OP_VSPAN = 2'd2;
   localparam logic [1:0] OP_RECT  = 2'd3;

   localparam logic [DIM_W-1:0]    RESET_SCREEN_WIDTH  = DIM_W'(640);
   localparam logic [DIM_W-1:0]    RESET_SCREEN_HEIGHT = DIM_W'(480);
   localparam logic [STRIDE_W-1:0] RESET_ROW_STRIDE    = STRIDE_W'(640);
   localparam logic [SHIFT_W-1:0]  RESET_RED_POS       = SHIFT_W'(16);
   localparam logic [SHIFT_W-1:0]  RESET_GREEN_POS     = SHIFT_W'(8);
   localparam logic [SHIFT_W-1:0]  RESET_BLUE_POS      = SHIFT_W'(0);

   typedef struct packed {
      logic                       enable;
      logic [DIM_W-1:0]           screen_width;
      logic [DIM_W-1:0]           screen_height;
      logic [STRIDE_W-1:0]        row_stride;
      logic [SHIFT_W-1:0]         red_pos;
      logic [SHIFT_W-1:0]         green_pos;
      logic [SHIFT_W-1:0]         blue_pos;
   } cfg_type;

   typedef struct packed {
      logic                       req_type;
      logic [1:0]                 draw_op;
      logic signed [FIELD_W-1:0]  origin_x;
      logic signed [FIELD_W-1:0]  origin_y;
      logic signed [FIELD_W-1:0]  span_width;
      logic signed [FIELD_W-1:0]  span_height;
      logic [COLOR_W-1:0]         red;
      logic [COLOR_W-1:0]         green;
      logic [COLOR_W-1:0]         blue;
   } cmd_type;

   typedef struct packed {
      logic                       is_draw;
      logic                       keep;
      logic [POS_W-1:0]           x;
      logic [POS_W-1:0]           y;
      logic [DIM_W-1:0]           w;
      logic [DIM_W-1:0]           h;
      logic [PIX_W-1:0]           pixel;
   } prep_type;

   typedef struct packed {
      logic                       is_draw;
      logic                       keep;
      logic [ADDR_W-1:0]          addr;
      logic [DIM_W-1:0]           w;
      logic [DIM_W-1:0]           h;
      logic [PIX_W-1:0]           pixel;
   } job_type;

   typedef struct packed {
      logic signed [CLIP_W-1:0]   pos;
      logic signed [CLIP_W-1:0]   len;
   } axis_type;

   function automatic logic [DIM_W-1:0] sat_dim(input logic [CSR_DIM_BITS-1:0] v);
      if (32'(v) > 32'(MAX_DIM)) begin
         return DIM_W'(MAX_DIM);
      end
      return DIM_W'(v);
   endfunction

   function automatic logic [STRIDE_W-1:0] sat_stride(input logic [CSR_STR_BITS-1:0] v);
      if (32'(v) > 32'(MAX_STRIDE)) begin
         return STRIDE_W'(MAX_STRIDE);
      end
      return STRIDE_W'(v);
   endfunction

endpackage

FILE: hw/rtl/clipped_rect_fill_engine_top.sv
`timescale 1ns / 1ps

// Solid-fill engine: a transaction with tuser 0 loads a draw command (when enabled,
// idle and non-empty on screen), which is clipped to the screen and turned into a start
// word offset; each later transaction with tuser 1 yields one framebuffer write while
// a shape is active, walking the shape row by row. The engine takes one transaction
// per cycle and returns one write per cycle while the write output is not stalled,
// and each write passes through the input register, the clip and colour pack
// register, the row-stride multiplier register and the walker's output register.
// Configuration registers take effect for transactions taken after the write and
// should be changed only while no transaction is in flight.

module clipped_rect_fill_engine_top
   import rcfe_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // draw_op, origin_x, origin_y, span_width, span_height, red, green, blue, zero fill
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   // req_type
   input  logic [0:0]             req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // word_offset, pixel_word, zero fill
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   output logic                   rsp_tlast,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type           cfg_ff, cfg_in;
   cmd_type           cmd;
   logic              clip_valid, clip_ready;
   prep_type          clip_prep;
   logic              addr_valid, addr_ready;
   job_type           addr_job;
   logic [ADDR_W-1:0] rsp_offset;
   logic [PIX_W-1:0]  rsp_pixel;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_ENABLE:        cfg_in.enable        = csr_wdata[0];
            CSR_SCREEN_WIDTH:  cfg_in.screen_width  = sat_dim(csr_wdata[CSR_DIM_BITS-1:0]);
            CSR_SCREEN_HEIGHT: cfg_in.screen_height = sat_dim(csr_wdata[CSR_DIM_BITS-1:0]);
            CSR_ROW_STRIDE:    cfg_in.row_stride    = sat_stride(csr_wdata[CSR_STR_BITS-1:0]);
            CSR_RED_POS:       cfg_in.red_pos       = csr_wdata[SHIFT_W-1:0];
            CSR_GREEN_POS:     cfg_in.green_pos     = csr_wdata[SHIFT_W-1:0];
            CSR_BLUE_POS:      cfg_in.blue_pos      = csr_wdata[SHIFT_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable        <= 1'b0;
         cfg_ff.screen_width  <= RESET_SCREEN_WIDTH;
         cfg_ff.screen_height <= RESET_SCREEN_HEIGHT;
         cfg_ff.row_stride    <= RESET_ROW_STRIDE;
         cfg_ff.red_pos       <= RESET_RED_POS;
         cfg_ff.green_pos     <= RESET_GREEN_POS;
         cfg_ff.blue_pos      <= RESET_BLUE_POS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      cmd.req_type    = req_tuser[0];
      cmd.draw_op     = req_tdata[1:0];
      cmd.origin_x    = req_tdata[17:2];
      cmd.origin_y    = req_tdata[33:18];
      cmd.span_width  = req_tdata[49:34];
      cmd.span_height = req_tdata[65:50];
      cmd.red         = req_tdata[73:66];
      cmd.green       = req_tdata[81:74];
      cmd.blue        = req_tdata[89:82];
   end

   rcfe_clip u_clip (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_cmd    (cmd),
      .out_valid (clip_valid),
      .out_ready (clip_ready),
      .out_prep  (clip_prep)
   );

   rcfe_addr u_addr (
      .clock      (clock),
      .reset      (reset),
      .row_stride (cfg_ff.row_stride),
      .in_valid   (clip_valid),
      .in_ready   (clip_ready),
      .in_prep    (clip_prep),
      .out_valid  (addr_valid),
      .out_ready  (addr_ready),
      .out_job    (addr_job)
   );

   rcfe_walk u_walk (
      .clock      (clock),
      .reset      (reset),
      .enable     (cfg_ff.enable),
      .row_stride (cfg_ff.row_stride),
      .in_valid   (addr_valid),
      .in_ready   (addr_ready),
      .in_job     (addr_job),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_offset (rsp_offset),
      .rsp_pixel  (rsp_pixel),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {(RSP_DATA_W - ADDR_W - PIX_W)'(0), rsp_pixel, rsp_offset};

endmodule

FILE: hw/rtl/rcfe_clip.sv
`timescale 1ns / 1ps

module rcfe_clip
   import rcfe_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     in_valid,
   output logic     in_ready,
   input  cmd_type  in_cmd,
   output logic     out_valid,
   input  logic     out_ready,
   output prep_type out_prep
);

   logic     s0_valid_ff, s0_valid_in;
   cmd_type  cmd_ff;
   logic     s1_valid_ff, s1_valid_in;
   prep_type prep_ff, prep_in;
   logic     s1_ready;

   logic signed [CLIP_W-1:0] len_x, len_y;
   axis_type ax_x, ax_y;

   function automatic axis_type clip_axis(input logic signed [CLIP_W-1:0] pos,
                                          input logic signed [CLIP_W-1:0] len,
                                          input logic signed [CLIP_W-1:0] lim);
      axis_type r;
      r.pos = pos;
      r.len = len;
      if (pos < 0) begin
         r.len = len + pos;
         r.pos = '0;
      end
      if (r.pos + r.len > lim) begin
         r.len = lim - r.pos;
      end
      return r;
   endfunction

   assign s1_ready = !s1_valid_ff || out_ready;
   assign in_ready = !s0_valid_ff || s1_ready;

   assign s0_valid_in = in_ready ? in_valid : s0_valid_ff;
   assign s1_valid_in = s1_ready ? s0_valid_ff : s1_valid_ff;

   always_comb begin
      len_x = CLIP_W'(1);
      len_y = CLIP_W'(1);
      if (cmd_ff.draw_op == OP_HSPAN || cmd_ff.draw_op == OP_RECT) begin
         len_x = CLIP_W'(cmd_ff.span_width);
      end
      if (cmd_ff.draw_op == OP_VSPAN || cmd_ff.draw_op == OP_RECT) begin
         len_y = CLIP_W'(cmd_ff.span_height);
      end
      ax_x = clip_axis(CLIP_W'(cmd_ff.origin_x), len_x,
                       signed'(CLIP_W'(cfg.screen_width)));
      ax_y = clip_axis(CLIP_W'(cmd_ff.origin_y), len_y,
                       signed'(CLIP_W'(cfg.screen_height)));

      prep_in.is_draw = (cmd_ff.req_type == REQ_DRAW);
      prep_in.keep    = (ax_x.len > 0) && (ax_y.len > 0);
      prep_in.x       = ax_x.pos[POS_W-1:0];
      prep_in.y       = ax_y.pos[POS_W-1:0];
      prep_in.w       = ax_x.len[DIM_W-1:0];
      prep_in.h       = ax_y.len[DIM_W-1:0];
      prep_in.pixel   = (PIX_W'(cmd_ff.red)   << cfg.red_pos)
                      | (PIX_W'(cmd_ff.green) << cfg.green_pos)
                      | (PIX_W'(cmd_ff.blue)  << cfg.blue_pos);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= s0_valid_in;
         s1_valid_ff <= s1_valid_in;
      end
      if (in_ready) begin
         cmd_ff <= in_cmd;
      end
      if (s1_ready) begin
         prep_ff <= prep_in;
      end
   end

   assign out_valid = s1_valid_ff;
   assign out_prep  = prep_ff;

endmodule

FILE: hw/rtl/rcfe_addr.sv
`timescale 1ns / 1ps

module rcfe_addr
   import rcfe_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic [STRIDE_W-1:0] row_stride,
   input  logic                in_valid,
   output logic                in_ready,
   input  prep_type            in_prep,
   output logic                out_valid,
   input  logic                out_ready,
   output job_type             out_job
);

   logic              valid_ff, valid_in;
   job_type           job_ff, job_in;
   logic [PROD_W-1:0] prod;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      prod           = PROD_W'(in_prep.y) * PROD_W'(row_stride);
      job_in.is_draw = in_prep.is_draw;
      job_in.keep    = in_prep.keep;
      job_in.addr    = ADDR_W'(prod + PROD_W'(in_prep.x));
      job_in.w       = in_prep.w;
      job_in.h       = in_prep.h;
      job_in.pixel   = in_prep.pixel;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready) begin
         job_ff <= job_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_job   = job_ff;

endmodule

FILE: hw/rtl/rcfe_walk.sv
`timescale 1ns / 1ps

module rcfe_walk
   import rcfe_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                enable,
   input  logic [STRIDE_W-1:0] row_stride,
   input  logic                in_valid,
   output logic                in_ready,
   input  job_type             in_job,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [ADDR_W-1:0]   rsp_offset,
   output logic [PIX_W-1:0]    rsp_pixel,
   output logic                rsp_last
);

   logic              busy_ff, busy_in;
   logic [ADDR_W-1:0] cur_ff, cur_in;
   logic [ADDR_W-1:0] row_ff, row_in;
   logic [DIM_W-1:0]  cols_left_ff, cols_left_in;
   logic [DIM_W-1:0]  cols_row_ff, cols_row_in;
   logic [DIM_W-1:0]  rows_left_ff, rows_left_in;
   logic [PIX_W-1:0]  pixel_ff, pixel_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0] rsp_offset_ff;
   logic [PIX_W-1:0]  rsp_pixel_ff;
   logic              rsp_last_ff;
   logic              take, out_load, last;

   assign in_ready = !rsp_valid_ff || rsp_ready;
   assign take     = in_valid && in_ready;
   assign last     = (cols_left_ff <= DIM_W'(1)) && (rows_left_ff <= DIM_W'(1));

   always_comb begin
      busy_in      = busy_ff;
      cur_in       = cur_ff;
      row_in       = row_ff;
      cols_left_in = cols_left_ff;
      cols_row_in  = cols_row_ff;
      rows_left_in = rows_left_ff;
      pixel_in     = pixel_ff;
      out_load     = 1'b0;
      if (take) begin
         if (in_job.is_draw) begin
            if (enable && !busy_ff && in_job.keep) begin
               busy_in      = 1'b1;
               cur_in       = in_job.addr;
               row_in       = in_job.addr;
               cols_left_in = in_job.w;
               cols_row_in  = in_job.w;
               rows_left_in = in_job.h;
               pixel_in     = in_job.pixel;
            end
         end else if (busy_ff) begin
            out_load = 1'b1;
            if (last) begin
               busy_in      = 1'b0;
               cols_left_in = '0;
               rows_left_in = '0;
            end else if (cols_left_ff > DIM_W'(1)) begin
               cols_left_in = cols_left_ff - DIM_W'(1);
               cur_in       = cur_ff + ADDR_W'(1);
            end else begin
               rows_left_in = rows_left_ff - DIM_W'(1);
               row_in       = row_ff + ADDR_W'(row_stride);
               cur_in       = row_ff + ADDR_W'(row_stride);
               cols_left_in = cols_row_ff;
            end
         end
      end
      rsp_valid_in = out_load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         cur_ff       <= '0;
         row_ff       <= '0;
         cols_left_ff <= '0;
         cols_row_ff  <= '0;
         rows_left_ff <= '0;
         pixel_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         cur_ff       <= cur_in;
         row_ff       <= row_in;
         cols_left_ff <= cols_left_in;
         cols_row_ff  <= cols_row_in;
         rows_left_ff <= rows_left_in;
         pixel_ff     <= pixel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (out_load) begin
         rsp_offset_ff <= cur_ff;
         rsp_pixel_ff  <= pixel_ff;
         rsp_last_ff   <= last;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_offset = rsp_offset_ff;
   assign rsp_pixel  = rsp_pixel_ff;
   assign rsp_last   = rsp_last_ff;

   a_busy_counts: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (cols_left_ff != '0 && rows_left_ff != '0))
      else $error("busy with an empty column or row count");

   a_cols_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (cols_left_ff <= cols_row_ff))
      else $error("column count exceeds the clipped width");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (out_load && last) |=> !busy_ff)
      else $error("engine still busy after the final write");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(busy_ff))
      else $error("result produced while idle");

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;
   import rcfe_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 3'd7;
   localparam int STALL_LIMIT = 3000;
   localparam int SETTLE_CYCLES = 8;

   typedef enum logic [1:0] {CHECK_MODEL, CHECK_NONE, CHECK_WRITE} check_kind_type;

   typedef struct packed {
      logic [ADDR_W-1:0] offset;
      logic [PIX_W-1:0]  pixel;
      logic              last;
   } fill_write_type;

   typedef struct {
      bit             enable_first;
      cmd_type        item;
      check_kind_type check;
      fill_write_type write;
   } directed_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic [0:0]             req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   clipped_rect_fill_engine_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   cfg_type           fill_cfg;
   logic              fill_busy;
   logic [ADDR_W-1:0] fill_addr;
   logic [ADDR_W-1:0] fill_row_addr;
   logic [DIM_W-1:0]  fill_cols_left;
   logic [DIM_W-1:0]  fill_cols_per_row;
   logic [DIM_W-1:0]  fill_rows_left;
   logic [PIX_W-1:0]  fill_pixel;

   fill_write_type   expected_writes[$];
   directed_row_type directed_rows[$];

   int  errors = 0;
   int  items_sent = 0;
   int  draws_loaded = 0;
   int  writes_checked = 0;
   int  reg_writes = 0;
   int  stall_cycles = 0;
   bit  steady = 1'b0;

   function automatic bit clip_shape(input cmd_type c, output longint x, output longint y,
                                     output longint w, output longint h);
      longint sw;
      longint sh;
      sw = longint'(fill_cfg.screen_width);
      sh = longint'(fill_cfg.screen_height);
      x = longint'($signed(c.origin_x));
      y = longint'($signed(c.origin_y));
      w = 1;
      h = 1;
      if (c.draw_op == OP_HSPAN || c.draw_op == OP_RECT) w = longint'($signed(c.span_width));
      if (c.draw_op == OP_VSPAN || c.draw_op == OP_RECT) h = longint'($signed(c.span_height));
      if (x < 0) begin
         w += x;
         x = 0;
      end
      if (x + w > sw) w = sw - x;
      if (y < 0) begin
         h += y;
         y = 0;
      end
      if (y + h > sh) h = sh - y;
      return (w > 0) && (h > 0);
   endfunction

   function automatic bit predict_fill(input cmd_type c, output fill_write_type wr);
      longint x, y, w, h;
      bit     last_one;
      wr = '0;
      if (c.req_type == REQ_DRAW) begin
         if (fill_cfg.enable && !fill_busy && clip_shape(c, x, y, w, h)) begin
            fill_pixel = (PIX_W'(c.red) << fill_cfg.red_pos)
                       | (PIX_W'(c.green) << fill_cfg.green_pos)
                       | (PIX_W'(c.blue) << fill_cfg.blue_pos);
            fill_row_addr = ADDR_W'(y * longint'(fill_cfg.row_stride) + x);
            fill_addr = fill_row_addr;
            fill_cols_per_row = DIM_W'(w);
            fill_cols_left = DIM_W'(w);
            fill_rows_left = DIM_W'(h);
            fill_busy = 1'b1;
         end
         return 1'b0;
      end
      if (!fill_busy) return 1'b0;
      last_one = (fill_cols_left <= 1) && (fill_rows_left <= 1);
      wr = '{offset: fill_addr, pixel: fill_pixel, last: last_one};
      if (last_one) begin
         fill_busy = 1'b0;
         fill_cols_left = '0;
         fill_rows_left = '0;
      end else if (fill_cols_left > 1) begin
         fill_cols_left--;
         fill_addr = fill_addr + 1'b1;
      end else begin
         fill_rows_left--;
         fill_row_addr = fill_row_addr + ADDR_W'(fill_cfg.row_stride);
         fill_addr = fill_row_addr;
         fill_cols_left = fill_cols_per_row;
      end
      return 1'b1;
   endfunction

   function automatic cmd_type random_item();
      cmd_type c;
      c.req_type = REQ_ADVANCE;
      c.draw_op = 2'($urandom);
      c.origin_x = 16'($urandom);
      c.origin_y = 16'($urandom);
      c.span_width = 16'($urandom);
      c.span_height = 16'($urandom);
      c.red = 8'($urandom);
      c.green = 8'($urandom);
      c.blue = 8'($urandom);
      return c;
   endfunction

   function automatic logic [FIELD_W-1:0] random_coord(input int limit);
      case ($urandom_range(9))
         0: return 16'($urandom);
         1, 2: return 16'($urandom_range(0, 6)) - 16'd3;
         default: return 16'($urandom_range(0, limit + 16)) - 16'd8;
      endcase
   endfunction

   function automatic logic [FIELD_W-1:0] random_size();
      case ($urandom_range(19))
         0, 1: return 16'($urandom);
         2: begin
            case ($urandom_range(3))
               0: return 16'h7FFF;
               1: return 16'h8000;
               2: return 16'h0000;
               default: return 16'hFFFF;
            endcase
         end
         default: return 16'($urandom_range(0, 14)) - 16'd3;
      endcase
   endfunction

   function automatic cmd_type random_draw();
      cmd_type c;
      longint  x, y, w, h;
      c = random_item();
      c.req_type = REQ_DRAW;
      do begin
         c.origin_x = random_coord(int'(fill_cfg.screen_width));
         c.origin_y = random_coord(int'(fill_cfg.screen_height));
         c.span_width = random_size();
         c.span_height = random_size();
      end while (clip_shape(c, x, y, w, h) && w * h > 400);
      return c;
   endfunction

   function automatic void add_row(input bit en, input logic typ, input logic [1:0] op,
                                   input int x, input int y, input int w, input int h,
                                   input logic [7:0] r, input logic [7:0] g,
                                   input logic [7:0] b, input check_kind_type k,
                                   input logic [ADDR_W-1:0] off = '0,
                                   input logic [PIX_W-1:0] pix = '0);
      directed_row_type row;
      row.enable_first = en;
      row.item = '{req_type: typ, draw_op: op, origin_x: 16'(x), origin_y: 16'(y),
                   span_width: 16'(w), span_height: 16'(h), red: r, green: g, blue: b};
      row.check = k;
      row.write = '{offset: off, pixel: pix, last: 1'b1};
      directed_rows.push_back(row);
   endfunction

   task automatic send_item(input cmd_type c, input check_kind_type how,
                            input fill_write_type typed, output bit effective);
      fill_write_type wr;
      bit             was_busy;
      bit             got;
      if (!steady && $urandom_range(99) < 16) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= c.req_type;
      req_tdata <= {6'd0, c.blue, c.green, c.red, c.span_height, c.span_width,
                    c.origin_y, c.origin_x, c.draw_op};
      do @(posedge clock); while (!req_tready);
      items_sent++;
      was_busy = fill_busy;
      got = predict_fill(c, wr);
      effective = got || (c.req_type == REQ_DRAW && !was_busy && fill_busy);
      if (c.req_type == REQ_DRAW && !was_busy && fill_busy) draws_loaded++;
      case (how)
         CHECK_MODEL: if (got) expected_writes.push_back(wr);
         CHECK_WRITE: expected_writes.push_back(typed);
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      logic [CSR_DIM_BITS-1:0] dim;
      logic [CSR_STR_BITS-1:0] stride;
      req_tvalid <= 1'b0;
      while (expected_writes.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      reg_writes++;
      dim = value[CSR_DIM_BITS-1:0];
      stride = value[CSR_STR_BITS-1:0];
      case (index)
         CSR_ENABLE: fill_cfg.enable = value[0];
         CSR_SCREEN_WIDTH:
            fill_cfg.screen_width = (dim > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(dim);
         CSR_SCREEN_HEIGHT:
            fill_cfg.screen_height = (dim > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(dim);
         CSR_ROW_STRIDE:
            fill_cfg.row_stride = (stride > MAX_STRIDE) ? STRIDE_W'(MAX_STRIDE)
                                                         : STRIDE_W'(stride);
         CSR_RED_POS: fill_cfg.red_pos = value[SHIFT_W-1:0];
         CSR_GREEN_POS: fill_cfg.green_pos = value[SHIFT_W-1:0];
         CSR_BLUE_POS: fill_cfg.blue_pos = value[SHIFT_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_phase(input int target);
      int      sent;
      cmd_type c;
      bit      eff;
      sent = 0;
      while (sent < target) begin
         steady = (target >= 500) && (sent >= 100) && (sent < 300);
         if (fill_busy ? ($urandom_range(9) != 0) : ($urandom_range(3) == 0)) begin
            c = random_item();
         end else begin
            c = random_draw();
         end
         send_item(c, CHECK_MODEL, '0, eff);
         sent++;
      end
      steady = 1'b0;
   endtask

   initial begin
      int             hold_left;
      bit             held;
      fill_write_type got;
      fill_write_type want;
      hold_left = 0;
      held = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got = '{offset: rsp_tdata[ADDR_W-1:0], pixel: rsp_tdata[ADDR_W+PIX_W-1:ADDR_W],
                    last: rsp_tlast};
            writes_checked++;
            if (expected_writes.size() == 0) begin
               $error("unexpected write transaction at word_offset %0d", got.offset);
               errors++;
            end else begin
               want = expected_writes.pop_front();
               if (got.offset !== want.offset) begin
                  $error("word_offset: expected %0d, actual %0d", want.offset, got.offset);
                  errors++;
               end
               if (got.pixel !== want.pixel) begin
                  $error("pixel_word: expected %h, actual %h", want.pixel, got.pixel);
                  errors++;
               end
               if (got.last !== want.last) begin
                  $error("last_write: expected %0d, actual %0d", want.last, got.last);
                  errors++;
               end
            end
         end
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!held && writes_checked >= 250) begin
            held = 1'b1;
            hold_left = 300;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= steady || ($urandom_range(99) >= 16);
         end
      end
   end

   initial begin
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
             || (csr_valid && csr_ready)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
      end
      $display("clipped_rect_fill_engine_top regression: fail");
      $finish;
   end

   initial begin
      bit eff;
      fill_cfg = '{enable: 1'b0, screen_width: RESET_SCREEN_WIDTH,
                   screen_height: RESET_SCREEN_HEIGHT, row_stride: RESET_ROW_STRIDE,
                   red_pos: RESET_RED_POS, green_pos: RESET_GREEN_POS,
                   blue_pos: RESET_BLUE_POS};
      fill_busy = 1'b0;
      fill_addr = '0;
      fill_row_addr = '0;
      fill_cols_left = '0;
      fill_cols_per_row = '0;
      fill_rows_left = '0;
      fill_pixel = '0;

      add_row(0, REQ_DRAW, OP_PIXEL, 5, 5, 0, 0, 8'h11, 8'h22, 8'h33, CHECK_NONE);
      add_row(0, REQ_ADVANCE, OP_PIXEL, 0, 0, 0, 0, 8'h00, 8'h00, 8'h00, CHECK_NONE);
      add_row(1, REQ_ADVANCE, OP_RECT, -1, -1, -1, -1, 8'hFF, 8'hFF, 8'hFF, CHECK_NONE);
      add_row(0, REQ_DRAW, OP_PIXEL, 0, 0, 0, 0, 8'hFF, 8'h00, 8'h00, CHECK_NONE);
      add_row(0, REQ_ADVANCE, OP_PIXEL, 0, 0, 0, 0, 8'h00, 8'h00, 8'h00, CHECK_WRITE,
              25'd0, 32'h00FF_0000);
      add_row(0, REQ_DRAW, OP_PIXEL, 639, 479, -32768, 32767, 8'h01, 8'h02, 8'h03,
              CHECK_NONE);
      add_row(0, REQ_ADVANCE, OP_PIXEL, 0, 0, 0, 0, 8'h00, 8'h00, 8'h00, CHECK_WRITE,
              25'd307199, 32'h0001_0203);
      add_row(0, REQ_DRAW, OP_PIXEL, 640, 0, 1, 1, 8'hFF, 8'hFF, 8'hFF, CHECK_NONE);
      add_row(0, REQ_ADVANCE, OP_PIXEL, 0, 0, 0, 0, 8'h00, 8'h00, 8'h00, CHECK_NONE);
      add_row(0, REQ_DRAW, OP_HSPAN, -2, 5, 4, -1, 8'h80, 8'h40, 8'h20, CHECK_MODEL);
      add_row(0, REQ_ADVANCE, OP_PIXEL, 0, 0, 0, 0, 8'h00, 8'h00, 8'h00, CHECK_MODEL);
      add_row(0, REQ_ADVANCE, OP_PIXEL, 0, 0, 0, 0, 8'h00, 8'h00, 8'h00, CHECK_MODEL);
      add_row(0, REQ_DRAW, OP_VSPAN, 10, 478, 0, 5, 8'h00, 8'hFF, 8'h00, CHECK_MODEL);
      add_row(0, REQ_ADVANCE, OP_PIXEL, 0, 0, 0, 0, 8'h00, 8'h00, 8'h00, CHECK_MODEL);
      add_row(0, REQ_DRAW, OP_RECT, 0, 0, 3, 3, 8'h00, 8'h00, 8'hFF, CHECK_MODEL);
      add_row(0, REQ_ADVANCE, OP_PIXEL, 0, 0, 0, 0, 8'h00, 8'h00, 8'h00, CHECK_MODEL);
      add_row(0, REQ_DRAW, OP_RECT, 638, 1, 5, 2, 8'h7F, 8'h80, 8'h01, CHECK_MODEL);
      repeat (4) add_row(0, REQ_ADVANCE, OP_PIXEL, 0, 0, 0, 0, 8'h00, 8'h00, 8'h00,
                         CHECK_MODEL);
      add_row(0, REQ_DRAW, OP_HSPAN, 3, 3, -5, 4, 8'hFF, 8'hFF, 8'hFF, CHECK_NONE);
      add_row(0, REQ_DRAW, OP_RECT, -32768, 32767, 32767, -32768, 8'hFF, 8'hFF, 8'hFF,
              CHECK_NONE);
      add_row(0, REQ_ADVANCE, OP_PIXEL, 0, 0, 0, 0, 8'h00, 8'h00, 8'h00, CHECK_NONE);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].enable_first) write_reg(CSR_ENABLE, 16'd1);
         send_item(directed_rows[i].item, directed_rows[i].check, directed_rows[i].write, eff);
      end

      run_phase(600);

      write_reg(CSR_SCREEN_WIDTH, 16'h1FFF);
      write_reg(CSR_SCREEN_HEIGHT, 16'hFFFF);
      write_reg(CSR_ROW_STRIDE, 16'h3FFF);
      write_reg(CSR_RED_POS, 16'd24);
      write_reg(CSR_GREEN_POS, 16'd24);
      write_reg(CSR_BLUE_POS, 16'd24);
      run_phase(400);

      write_reg(CSR_SCREEN_WIDTH, 16'd1);
      write_reg(CSR_SCREEN_HEIGHT, 16'd1);
      write_reg(CSR_ROW_STRIDE, 16'd0);
      write_reg(CSR_RED_POS, 16'hFFFF);
      write_reg(CSR_GREEN_POS, 16'h001F);
      write_reg(CSR_BLUE_POS, 16'hAAFF);
      run_phase(250);

      write_reg(CSR_SCREEN_WIDTH, 16'd0);
      write_reg(CSR_SCREEN_HEIGHT, 16'd0);
      write_reg(CSR_UNUSED, 16'h5A5A);
      run_phase(60);

      write_reg(CSR_SCREEN_WIDTH, 16'hE011);
      write_reg(CSR_SCREEN_HEIGHT, 16'd9);
      write_reg(CSR_ROW_STRIDE, 16'd20);
      write_reg(CSR_RED_POS, 16'd5);
      write_reg(CSR_GREEN_POS, 16'd13);
      write_reg(CSR_BLUE_POS, 16'd29);
      write_reg(CSR_ENABLE, 16'h8001);
      run_phase(300);

      write_reg(CSR_ENABLE, 16'hFFFE);
      run_phase(40);

      write_reg(CSR_ENABLE, 16'd1);
      write_reg(CSR_SCREEN_WIDTH, 16'd3);
      write_reg(CSR_SCREEN_HEIGHT, 16'd4096);
      write_reg(CSR_ROW_STRIDE, 16'd1);
      write_reg(CSR_RED_POS, 16'd0);
      write_reg(CSR_GREEN_POS, 16'd8);
      write_reg(CSR_BLUE_POS, 16'd16);
      run_phase(250);

      req_tvalid <= 1'b0;
      while (expected_writes.size() != 0) @(negedge clock);
      repeat (2 * SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d request transactions; %0d draws loaded and %0d writes checked.",
               items_sent, draws_loaded, writes_checked);
      $display("Applied %0d register writes across default, saturated, tiny and zero screens.",
               reg_writes);
      if (errors == 0) begin
         $display("clipped_rect_fill_engine_top regression: pass");
      end else begin
         $display("clipped_rect_fill_engine_top regression: fail");
      end
      $finish;
   end

endmodule
